@@ hdl/rrm_pkg.sv @@
package rrm_pkg;

  // Defaults for the top-level parameters
  localparam int TABLE_DEPTH = 64;
  localparam int CODE_CHARS  = 3;

  // Fixed port widths
  localparam int CODE_PORT_W = 24;
  localparam int PIDX_W      = 6;
  localparam int MATCH_W     = 12;
  localparam int POS_W       = 7;

  localparam logic [MATCH_W-1:0] MATCH_MAX = '1;

  // One classified route on its way from the front part to the back part
  typedef struct packed {
    logic [CODE_PORT_W-1:0] dep;
    logic [CODE_PORT_W-1:0] arr;
    logic [POS_W-1:0]       pos;
    logic                   fin;
    logic                   drop;
  } route_cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_WAIT,
    BK_SELF,
    BK_FLUSH
  } back_state_t;

endpackage

@@ hdl/rrm_ram.sv @@
module rrm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/rrm_queue.sv @@
module rrm_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rrm_pkg::route_cmd_t push_cmd,
  input  logic                pop,
  output logic                valid,
  output rrm_pkg::route_cmd_t head_cmd,
  output logic                full
);

  rrm_pkg::route_cmd_t slots [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          fill;

  assign valid    = (fill != 2'd0);
  assign full     = (fill == 2'd2);
  assign head_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ hdl/rrm_front.sv @@
module rrm_front #(
  parameter int TABLE_DEPTH = rrm_pkg::TABLE_DEPTH,
  parameter int CODE_CHARS  = rrm_pkg::CODE_CHARS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            queue_full,
  input  logic [rrm_pkg::CODE_PORT_W-1:0] departure_code,
  input  logic [rrm_pkg::CODE_PORT_W-1:0] arrival_code,
  input  logic                            final_route,
  output logic                            push,
  output rrm_pkg::route_cmd_t             push_cmd
);

  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CODE_W = (8 * CODE_CHARS > rrm_pkg::CODE_PORT_W) ?
                          rrm_pkg::CODE_PORT_W : 8 * CODE_CHARS;
  localparam logic [rrm_pkg::CODE_PORT_W-1:0] CODE_MASK =
    rrm_pkg::CODE_PORT_W'((25'd1 << CODE_W) - 25'd1);

  logic [CNT_W-1:0] route_count;
  logic             accept;
  logic             table_full;

  assign accept     = start && !queue_full;
  assign table_full = (route_count == CNT_W'(TABLE_DEPTH));

  // Drop a route that finds the table full; pass it on only if it ends the set
  assign push = accept && (!table_full || final_route);

  always_comb begin
    push_cmd.dep  = departure_code & CODE_MASK;
    push_cmd.arr  = arrival_code & CODE_MASK;
    push_cmd.pos  = rrm_pkg::POS_W'(route_count);
    push_cmd.fin  = final_route;
    push_cmd.drop = table_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      route_count <= '0;
    end else if (accept) begin
      if (final_route) begin
        route_count <= '0;
      end else if (!table_full) begin
        route_count <= route_count + CNT_W'(1);
      end
    end
  end

endmodule

@@ hdl/rrm_back.sv @@
module rrm_back #(
  parameter int TABLE_DEPTH = rrm_pkg::TABLE_DEPTH,
  parameter int CODE_CHARS  = rrm_pkg::CODE_CHARS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  rrm_pkg::route_cmd_t             cmd_in,
  output logic                            cmd_pop,
  output logic                            strobe,
  output logic [rrm_pkg::CODE_PORT_W-1:0] match_departure,
  output logic [rrm_pkg::CODE_PORT_W-1:0] match_arrival,
  output logic [rrm_pkg::PIDX_W-1:0]      partner_index,
  output logic [rrm_pkg::MATCH_W-1:0]     matches_so_far,
  output logic                            last_of_run
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CODE_W = (8 * CODE_CHARS > rrm_pkg::CODE_PORT_W) ?
                          rrm_pkg::CODE_PORT_W : 8 * CODE_CHARS;
  localparam int RAM_W  = 2 * CODE_W;

  rrm_pkg::back_state_t        state;
  rrm_pkg::back_state_t        state_next;
  rrm_pkg::route_cmd_t         cmd;
  logic [IDX_W-1:0]            idx;
  logic [IDX_W-1:0]            cur_pos;
  logic                        rd_valid;
  logic [IDX_W-1:0]            rd_idx;
  logic [RAM_W-1:0]            rdata;
  logic                        pend_valid;
  logic [IDX_W-1:0]            pend_idx;
  logic [rrm_pkg::MATCH_W-1:0] pend_count;
  logic [rrm_pkg::MATCH_W-1:0] match_counter;
  logic [rrm_pkg::MATCH_W-1:0] count_inc;

  logic                        scan_done;
  logic                        rd_en;
  logic                        wr_en;
  logic                        flush;
  logic                        scan_hit;
  logic                        self_hit;
  logic                        hit;
  logic [IDX_W-1:0]            hit_idx;
  logic                        emit;

  assign cur_pos   = cmd.pos[IDX_W-1:0];
  assign scan_done = (idx == cur_pos);

  always_comb begin
    state_next = state;
    unique case (state)
      rrm_pkg::BK_IDLE: begin
        if (cmd_valid && !cmd_in.drop) begin
          state_next = rrm_pkg::BK_SCAN;
        end
      end
      rrm_pkg::BK_SCAN: begin
        if (scan_done) begin
          state_next = rrm_pkg::BK_WAIT;
        end
      end
      rrm_pkg::BK_WAIT:  state_next = rrm_pkg::BK_SELF;
      rrm_pkg::BK_SELF:  state_next = rrm_pkg::BK_FLUSH;
      rrm_pkg::BK_FLUSH: state_next = rrm_pkg::BK_IDLE;
      default:           state_next = rrm_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    flush   = 1'b0;
    unique case (state)
      rrm_pkg::BK_IDLE:  cmd_pop = cmd_valid;
      rrm_pkg::BK_SCAN:  rd_en   = !scan_done;
      rrm_pkg::BK_WAIT:  ;
      rrm_pkg::BK_SELF:  wr_en   = 1'b1;
      rrm_pkg::BK_FLUSH: flush   = 1'b1;
      default:           ;
    endcase
  end

  rrm_ram #(
    .WIDTH(RAM_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(cur_pos),
    .wdata({cmd.dep[CODE_W-1:0], cmd.arr[CODE_W-1:0]}),
    .re   (rd_en),
    .raddr(idx),
    .rdata(rdata)
  );

  // Stored route is the reverse of the new one
  assign scan_hit = rd_valid && (rdata[RAM_W-1:CODE_W] == cmd.arr[CODE_W-1:0]) &&
                    (rdata[CODE_W-1:0] == cmd.dep[CODE_W-1:0]);
  assign self_hit = (state == rrm_pkg::BK_SELF) && (cmd.dep == cmd.arr) && !cmd.fin;
  assign hit      = scan_hit || self_hit;
  assign hit_idx  = scan_hit ? rd_idx : cur_pos;
  assign count_inc = (match_counter == rrm_pkg::MATCH_MAX) ? match_counter :
                     match_counter + rrm_pkg::MATCH_W'(1);
  // Hold each match until the next one or the end of the item shows if it is the last
  assign emit = pend_valid && (hit || flush);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rrm_pkg::BK_IDLE;
      rd_valid      <= 1'b0;
      pend_valid    <= 1'b0;
      match_counter <= '0;
      strobe        <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_en;
      strobe   <= emit;
      if (cmd_pop && cmd_in.drop) begin
        match_counter <= '0;
      end else if (hit) begin
        match_counter <= count_inc;
      end else if (flush && cmd.fin) begin
        match_counter <= '0;
      end
      if (hit) begin
        pend_valid <= 1'b1;
      end else if (flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd <= cmd_in;
      idx <= '0;
    end else if (rd_en) begin
      idx <= idx + IDX_W'(1);
    end
    if (rd_en) begin
      rd_idx <= idx;
    end
    if (hit) begin
      pend_idx   <= hit_idx;
      pend_count <= count_inc;
    end
    if (emit) begin
      match_departure <= cmd.dep;
      match_arrival   <= cmd.arr;
      partner_index   <= rrm_pkg::PIDX_W'(pend_idx);
      matches_so_far  <= pend_count;
      last_of_run     <= flush;
    end
  end

endmodule

@@ hdl/reciprocal_route_matcher.sv @@
// Channel   Direction  Handshake               Fields
// command   in         start & !busy           departure_code, arrival_code, final_route
// result    out        strobe, one cycle only  match_departure, match_arrival,
//                                              partner_index, matches_so_far, last_of_run
//
// For each route the back part pops it from the queue, reads one table entry per cycle
// through the single read port of the route table and does the last compare, waits in an
// idle state, runs a self-match step that also writes the table, and flushes the last
// result. A dropped final route is popped without a scan.
// busy is high while the two-entry command queue is full.
// Reset is synchronous and clears the queue, the route count, the match counter and strobe.
// Results cannot be stalled; each one is shown for exactly one cycle.
module reciprocal_route_matcher #(
  parameter int TABLE_DEPTH = rrm_pkg::TABLE_DEPTH,
  parameter int CODE_CHARS  = rrm_pkg::CODE_CHARS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [rrm_pkg::CODE_PORT_W-1:0] departure_code,
  input  logic [rrm_pkg::CODE_PORT_W-1:0] arrival_code,
  input  logic                            final_route,
  output logic                            strobe,
  output logic [rrm_pkg::CODE_PORT_W-1:0] match_departure,
  output logic [rrm_pkg::CODE_PORT_W-1:0] match_arrival,
  output logic [rrm_pkg::PIDX_W-1:0]      partner_index,
  output logic [rrm_pkg::MATCH_W-1:0]     matches_so_far,
  output logic                            last_of_run
);

  logic                push;
  rrm_pkg::route_cmd_t push_cmd;
  logic                queue_full;
  logic                head_valid;
  rrm_pkg::route_cmd_t head_cmd;
  logic                pop;

  assign busy = queue_full;

  // Front: mask codes, assign table slots, drop routes once the table is full
  rrm_front #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .CODE_CHARS (CODE_CHARS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .queue_full    (queue_full),
    .departure_code(departure_code),
    .arrival_code  (arrival_code),
    .final_route   (final_route),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  // Decouple the front from the scan so a new word can land during a long scan
  rrm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .valid   (head_valid),
    .head_cmd(head_cmd),
    .full    (queue_full)
  );

  // Back: scan the table, count matches, store the route, emit results
  rrm_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .CODE_CHARS (CODE_CHARS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (head_valid),
    .cmd_in         (head_cmd),
    .cmd_pop        (pop),
    .strobe         (strobe),
    .match_departure(match_departure),
    .match_arrival  (match_arrival),
    .partner_index  (partner_index),
    .matches_so_far (matches_so_far),
    .last_of_run    (last_of_run)
  );

endmodule

@@ hdl/rrm_checker.sv @@
module rrm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            busy,
  input logic                            strobe,
  input logic [rrm_pkg::PIDX_W-1:0]      partner_index,
  input logic [rrm_pkg::MATCH_W-1:0]     matches_so_far,
  input logic                            last_of_run
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe && !busy)
    else $error("strobe or busy after reset");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    strobe |-> matches_so_far != '0)
    else $error("result with zero match count");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_of_run && matches_so_far != rrm_pkg::MATCH_MAX |=>
      !strobe || matches_so_far == $past(matches_so_far) + rrm_pkg::MATCH_W'(1))
    else $error("match count did not advance by one within a run");

  a_partner_rises: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_of_run |=> !strobe || partner_index > $past(partner_index))
    else $error("partner index not ascending within a run");

endmodule

bind reciprocal_route_matcher rrm_checker u_rrm_checker (
  .clk           (clk),
  .rst           (rst),
  .busy          (busy),
  .strobe        (strobe),
  .partner_index (partner_index),
  .matches_so_far(matches_so_far),
  .last_of_run   (last_of_run)
);
